[hdl/assert_macros.svh]
// Assertion macros shared by the tag nesting checker RTL.
// Needs nothing else; included by the modules that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define TNC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Checks that an expression never holds outside reset.
`define TNC_ASSERT_NEVER(label, clk, rstn, expr, msg) \
    `TNC_ASSERT(label, clk, rstn, !(expr), msg)

`endif

[hdl/tnc_pkg.sv]
// Shared types and constants of the markup tag nesting checker.
// Has no dependencies; tnc_front, tnc_queue, tnc_back and the top import it.
`default_nettype none

package tnc_pkg;

    localparam int DEF_STACK_DEPTH  = 32;
    localparam int DEF_MAX_NAME_LEN = 16;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_NL    = 8'h0A;

    localparam logic [15:0] LINE_MAX = 16'hFFFF;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_UNCLOSED    = 3'd1;
    localparam logic [2:0] ERR_BAD_CHAR    = 3'd2;
    localparam logic [2:0] ERR_MISMATCH    = 3'd3;
    localparam logic [2:0] ERR_OPEN_AT_END = 3'd4;
    localparam logic [2:0] ERR_TOO_LONG    = 3'd5;
    localparam logic [2:0] ERR_OVERFLOW    = 3'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } in_t;

    typedef struct packed {
        logic [2:0]  error_code;
        logic [15:0] error_line;
    } out_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic       is_lt;
        logic       is_gt;
        logic       is_nl;
        logic       is_slash;
        logic       name_ok;
    } tok_t;

endpackage

`default_nettype wire

[hdl/tnc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Has no dependencies; used for the tag stack storage.
`default_nettype none

module tnc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hdl/tnc_queue.sv]
// Short token queue between the classifying front and the stack back end.
// Depends on tnc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tnc_queue
    import tnc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire tok_t in_tok,
    output logic      out_valid,
    input  wire logic out_ready,
    output tok_t      out_tok
);

    localparam int QD   = QUEUE_DEPTH;
    localparam int PW   = (QD > 1) ? $clog2(QD) : 1;
    localparam int CW   = $clog2(QD + 1);

    tok_t           mem_reg [QD];
    logic [PW-1:0]  wptr_reg, wptr_next;
    logic [PW-1:0]  rptr_reg, rptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           push, pop;

    assign in_ready  = (count_reg != CW'(QD));
    assign out_valid = (count_reg != '0);
    assign out_tok   = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push) begin
            wptr_next = (wptr_reg == PW'(QD - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop) begin
            rptr_next = (rptr_reg == PW'(QD - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
        if (push) begin
            mem_reg[wptr_reg] <= in_tok;
        end
    end

    `TNC_ASSERT_NEVER(a_q_count_bound, aclk, aresetn, count_reg > CW'(QD), "queue count overrun")

endmodule

`default_nettype wire

[hdl/tnc_front.sv]
// Input stage: accepts document bytes and classifies them into tokens.
// Depends on tnc_pkg.
`default_nettype none

module tnc_front
    import tnc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      tok_valid,
    input  wire logic tok_ready,
    output tok_t      tok
);

    logic tok_valid_reg, tok_valid_next;
    tok_t tok_reg, tok_next;
    logic accept;
    logic [7:0] b;

    assign b         = s_data.data_byte;
    assign s_ready   = !tok_valid_reg || tok_ready;
    assign accept    = s_valid && s_ready;
    assign tok_valid = tok_valid_reg;
    assign tok       = tok_reg;

    always_comb begin
        tok_next.data_byte = b;
        tok_next.last      = s_data.last;
        tok_next.is_lt     = (b == CHAR_LT);
        tok_next.is_gt     = (b == CHAR_GT);
        tok_next.is_nl     = (b == CHAR_NL);
        tok_next.is_slash  = (b == CHAR_SLASH);
        tok_next.name_ok   = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
                             (b >= 8'h30 && b <= 8'h39) || (b == CHAR_SLASH);
        tok_valid_next     = accept || (tok_valid_reg && !tok_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_valid_reg <= 1'b0;
        end else begin
            tok_valid_reg <= tok_valid_next;
        end
        if (accept) begin
            tok_reg <= tok_next;
        end
    end

endmodule

`default_nettype wire

[hdl/tnc_back.sv]
// Back end: tag state, name stack in RAM, error tracking and result register.
// Depends on tnc_pkg, tnc_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tnc_back
    import tnc_pkg::*;
#(
    parameter int STACK_DEPTH  = DEF_STACK_DEPTH,
    parameter int MAX_NAME_LEN = DEF_MAX_NAME_LEN
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic q_valid,
    output logic      q_ready,
    input  wire tok_t q_tok,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    localparam int IDX_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DEP_W  = $clog2(STACK_DEPTH + 1);
    localparam int NL_W   = $clog2(MAX_NAME_LEN + 1);
    localparam int CHAR_N = STACK_DEPTH * MAX_NAME_LEN;
    localparam int CA_W   = (CHAR_N > 1) ? $clog2(CHAR_N) : 1;

    logic              inside_reg, inside_next;
    logic              started_reg, started_next;
    logic              closing_reg, closing_next;
    logic [NL_W-1:0]   nlen_reg, nlen_next;
    logic              bad_reg, bad_next;
    logic              long_reg, long_next;
    logic              mism_reg, mism_next;
    logic [DEP_W-1:0]  depth_reg, depth_next;
    logic [15:0]       line_reg, line_next;
    logic [2:0]        err_reg, err_next;
    logic [15:0]       eline_reg, eline_next;
    logic              m_valid_reg, m_valid_next;
    out_t              m_data_reg, m_data_next;
    logic              byp_reg, byp_next;
    logic [NL_W-1:0]   byp_data_reg;

    logic              step;
    logic [NL_W-1:0]   top_len;
    logic              char_we;
    logic [CA_W-1:0]   char_waddr, char_raddr;
    logic [7:0]        char_rdata;
    logic              len_we;
    logic [IDX_W-1:0]  len_waddr, len_raddr;
    logic [NL_W-1:0]   len_rdata;
    logic [2:0]        fin_err;

    assign step    = q_valid && (!q_tok.last || !m_valid_reg || m_ready);
    assign q_ready = step;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign top_len = byp_reg ? byp_data_reg : len_rdata;

    assign char_waddr = CA_W'(int'(depth_reg) * MAX_NAME_LEN + int'(nlen_reg));
    assign len_waddr  = IDX_W'(depth_reg);
    assign len_raddr  = IDX_W'(depth_next - 1'b1);
    assign char_raddr = CA_W'(int'(len_raddr) * MAX_NAME_LEN + int'(nlen_next));
    assign byp_next   = len_we && (len_waddr == len_raddr);

    always_comb begin
        inside_next  = inside_reg;
        started_next = started_reg;
        closing_next = closing_reg;
        nlen_next    = nlen_reg;
        bad_next     = bad_reg;
        long_next    = long_reg;
        mism_next    = mism_reg;
        depth_next   = depth_reg;
        line_next    = line_reg;
        err_next     = err_reg;
        eline_next   = eline_reg;
        char_we      = 1'b0;
        len_we       = 1'b0;
        fin_err      = ERR_NONE;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;

        if (step) begin
            if (err_reg == ERR_NONE) begin
                if (!inside_reg) begin
                    if (q_tok.is_lt) begin
                        inside_next  = 1'b1;
                        started_next = 1'b0;
                        closing_next = 1'b0;
                        nlen_next    = '0;
                        bad_next     = 1'b0;
                        long_next    = 1'b0;
                        mism_next    = 1'b0;
                    end else if (q_tok.is_nl && line_reg != LINE_MAX) begin
                        line_next = line_reg + 1'b1;
                    end
                end else if (q_tok.is_nl) begin
                    err_next   = ERR_UNCLOSED;
                    eline_next = line_reg;
                end else if (q_tok.is_gt) begin
                    inside_next = 1'b0;
                    if (bad_reg) begin
                        err_next   = ERR_BAD_CHAR;
                        eline_next = line_reg;
                    end else if (long_reg) begin
                        err_next   = ERR_TOO_LONG;
                        eline_next = line_reg;
                    end else if (closing_reg) begin
                        if (mism_reg || depth_reg == '0 || nlen_reg != top_len) begin
                            err_next   = ERR_MISMATCH;
                            eline_next = line_reg;
                        end else begin
                            depth_next = depth_reg - 1'b1;
                        end
                    end else if (depth_reg >= DEP_W'(STACK_DEPTH)) begin
                        err_next   = ERR_OVERFLOW;
                        eline_next = line_reg;
                    end else begin
                        len_we     = 1'b1;
                        depth_next = depth_reg + 1'b1;
                    end
                end else begin
                    started_next = 1'b1;
                    if (!started_reg && q_tok.is_slash) begin
                        closing_next = 1'b1;
                    end else begin
                        if (!q_tok.name_ok) begin
                            bad_next = 1'b1;
                        end
                        if (nlen_reg >= NL_W'(MAX_NAME_LEN)) begin
                            long_next = 1'b1;
                        end else begin
                            if (closing_reg) begin
                                if (depth_reg == '0 || nlen_reg >= top_len ||
                                    char_rdata != q_tok.data_byte) begin
                                    mism_next = 1'b1;
                                end
                            end else if (depth_reg < DEP_W'(STACK_DEPTH)) begin
                                char_we = 1'b1;
                            end
                            nlen_next = nlen_reg + 1'b1;
                        end
                    end
                end
            end

            if (q_tok.last) begin
                fin_err = err_next;
                if (err_next == ERR_NONE) begin
                    if (inside_next) begin
                        fin_err = ERR_UNCLOSED;
                    end else if (depth_next != '0) begin
                        fin_err = ERR_OPEN_AT_END;
                    end
                end
                m_data_next.error_code = fin_err;
                if (fin_err == ERR_NONE) begin
                    m_data_next.error_line = '0;
                end else if (err_next == ERR_NONE) begin
                    m_data_next.error_line = line_reg;
                end else begin
                    m_data_next.error_line = eline_next;
                end
                m_valid_next = 1'b1;
                inside_next  = 1'b0;
                started_next = 1'b0;
                closing_next = 1'b0;
                nlen_next    = '0;
                bad_next     = 1'b0;
                long_next    = 1'b0;
                mism_next    = 1'b0;
                depth_next   = '0;
                line_next    = 16'd1;
                err_next     = ERR_NONE;
                eline_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_reg   <= 1'b0;
            started_reg  <= 1'b0;
            closing_reg  <= 1'b0;
            nlen_reg     <= '0;
            bad_reg      <= 1'b0;
            long_reg     <= 1'b0;
            mism_reg     <= 1'b0;
            depth_reg    <= '0;
            line_reg     <= 16'd1;
            err_reg      <= ERR_NONE;
            eline_reg    <= '0;
            m_valid_reg  <= 1'b0;
            byp_reg      <= 1'b0;
        end else begin
            inside_reg   <= inside_next;
            started_reg  <= started_next;
            closing_reg  <= closing_next;
            nlen_reg     <= nlen_next;
            bad_reg      <= bad_next;
            long_reg     <= long_next;
            mism_reg     <= mism_next;
            depth_reg    <= depth_next;
            line_reg     <= line_next;
            err_reg      <= err_next;
            eline_reg    <= eline_next;
            m_valid_reg  <= m_valid_next;
            byp_reg      <= byp_next;
        end
        m_data_reg   <= m_data_next;
        byp_data_reg <= nlen_reg;
    end

    tnc_ram #(
        .WIDTH (8),
        .DEPTH (CHAR_N)
    ) u_char_ram (
        .clk   (aclk),
        .we    (char_we),
        .waddr (char_waddr),
        .wdata (q_tok.data_byte),
        .raddr (char_raddr),
        .rdata (char_rdata)
    );

    tnc_ram #(
        .WIDTH (NL_W),
        .DEPTH (STACK_DEPTH)
    ) u_len_ram (
        .clk   (aclk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (nlen_reg),
        .raddr (len_raddr),
        .rdata (len_rdata)
    );

    `TNC_ASSERT_NEVER(a_depth_bound, aclk, aresetn, depth_reg > DEP_W'(STACK_DEPTH),
        "stack depth out of range")
    `TNC_ASSERT_NEVER(a_nlen_bound, aclk, aresetn, nlen_reg > NL_W'(MAX_NAME_LEN),
        "name length out of range")
    `TNC_ASSERT(a_err_sticky, aclk, aresetn,
        (err_reg != ERR_NONE && !(step && q_tok.last)) |=> (err_reg == $past(err_reg)),
        "first error changed before document end")
    `TNC_ASSERT(a_valid_zero_line, aclk, aresetn,
        (m_valid_reg && m_data_reg.error_code == ERR_NONE) |-> (m_data_reg.error_line == '0),
        "valid document reports a line")

endmodule

`default_nettype wire

[hdl/markup_tag_nesting_checker_top.sv]
// Markup tag nesting checker: takes one document byte per beat, tracks tags on a
// name stack held in RAM, and returns one result beat (first error and its line)
// after the beat marked last. Sustained rate is one byte per clock unless a waiting
// result stalls a last byte; the stack entry that the next closing-name byte
// compares against is read ahead from the registered-read name RAM, and that
// prefetch sets the rate. A result passes the input register, token queue and
// result register after the edge that accepts its last byte. A result still
// waiting at the output holds back only the last byte of the next document. No clearing
// pass follows reset. Depends on tnc_pkg, tnc_front, tnc_queue and tnc_back.
`default_nettype none

module markup_tag_nesting_checker_top
    import tnc_pkg::*;
#(
    parameter int STACK_DEPTH  = DEF_STACK_DEPTH,
    parameter int MAX_NAME_LEN = DEF_MAX_NAME_LEN
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    logic f_valid, f_ready;
    tok_t f_tok;
    logic q_valid, q_ready;
    tok_t q_tok;

    tnc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .tok_valid (f_valid),
        .tok_ready (f_ready),
        .tok       (f_tok)
    );

    tnc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_tok    (f_tok),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_tok   (q_tok)
    );

    tnc_back #(
        .STACK_DEPTH  (STACK_DEPTH),
        .MAX_NAME_LEN (MAX_NAME_LEN)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_tok   (q_tok),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
